>>> rtl/msrd_pkg.sv
`timescale 1ns / 1ps
package msrd_pkg;

	// default sizing of the top level
	localparam int DEF_HISTORY_DEPTH = 4;
	localparam int DEF_COUNT_WIDTH   = 32;

	// fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int CC_W       = 3;
	localparam int SPACING_W  = 24;
	localparam int SAMPLES_W  = 32;
	localparam int DURATION_W = 56;
	localparam int CFG_DATA_W = SPACING_W;
	localparam int CFG_IDX_W  = 1;

	// register reset values
	localparam logic [CC_W-1:0]      CC_RESET      = 3'd4;
	localparam logic [SPACING_W-1:0] SPACING_RESET = 24'd5805;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AGREE_N = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPACING = 1'd1;

	// input commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	// finished element handed from the tracker to the output pipeline
	typedef struct packed {
		logic valid;
		logic mark;
		logic flush;
	} emit_t;

endpackage

>>> rtl/msrd_tracker.sv
`timescale 1ns / 1ps
module msrd_tracker #(
	parameter int HISTORY_DEPTH = msrd_pkg::DEF_HISTORY_DEPTH,
	parameter int COUNT_WIDTH   = msrd_pkg::DEF_COUNT_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         beat,
	input  logic                         command,
	input  logic [msrd_pkg::SAMPLE_W-1:0] sample,
	input  logic [msrd_pkg::CC_W-1:0]     agree_n,
	output msrd_pkg::emit_t              ev,
	output logic [COUNT_WIDTH-1:0]       ev_len
);
	import msrd_pkg::*;

	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int EXT_W  = (FILL_W > CC_W) ? FILL_W : CC_W;

	logic [HISTORY_DEPTH-1:0] zh_q;
	logic [FILL_W-1:0]        fill_q;
	logic [COUNT_WIDTH-1:0]   cnt_q;
	logic [COUNT_WIDTH-1:0]   start_q;
	logic                     held_q;
	logic                     first_q;

	logic [HISTORY_DEPTH:0]   zh_wide;
	logic [HISTORY_DEPTH-1:0] zh_next;
	logic [FILL_W-1:0]        fill_next;
	logic [EXT_W-1:0]         cc_ext;
	logic [FILL_W-1:0]        cmp;
	logic [HISTORY_DEPTH-1:0] cmask;
	logic [HISTORY_DEPTH-1:0] low;
	logic                     decided;
	logic                     dec_mark;
	logic                     is_flush;

	assign is_flush = (command == CMD_FLUSH);

	// shift the zero flag of the new sample into the history
	always_comb begin
		zh_wide   = {zh_q, (sample == '0)};
		zh_next   = zh_wide[HISTORY_DEPTH-1:0];
		fill_next = (fill_q < FILL_W'(HISTORY_DEPTH)) ? fill_q + FILL_W'(1) : fill_q;
	end

	// effective compare count, saturated to 1..depth
	always_comb begin
		cc_ext = EXT_W'(agree_n);
		if (agree_n == '0) begin
			cmp = FILL_W'(1);
		end else if (cc_ext > EXT_W'(HISTORY_DEPTH)) begin
			cmp = FILL_W'(HISTORY_DEPTH);
		end else begin
			cmp = FILL_W'(cc_ext);
		end
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			cmask[i] = (FILL_W'(i) < cmp);
		end
	end

	// all newest zero is space, none zero is mark
	always_comb begin
		low      = zh_next & cmask;
		dec_mark = (low == '0);
		decided  = (fill_next >= cmp) && ((low == cmask) || dec_mark);
	end

	// finished element for this beat
	always_comb begin
		ev.valid = 1'b0;
		ev.mark  = held_q;
		ev.flush = is_flush;
		ev_len   = cnt_q - start_q;
		if (beat) begin
			if (is_flush) begin
				ev.valid = 1'b1;
			end else if (decided && first_q && (dec_mark != held_q)) begin
				ev.valid = 1'b1;
			end
		end
	end

	// run tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zh_q    <= '0;
			fill_q  <= '0;
			cnt_q   <= '0;
			start_q <= '0;
			held_q  <= 1'b0;
			first_q <= 1'b0;
		end else if (beat) begin
			if (is_flush) begin
				zh_q    <= '0;
				fill_q  <= '0;
				cnt_q   <= '0;
				start_q <= '0;
				held_q  <= 1'b0;
				first_q <= 1'b0;
			end else begin
				zh_q   <= zh_next;
				fill_q <= fill_next;
				cnt_q  <= cnt_q + COUNT_WIDTH'(1);
				if (decided && (!first_q || (dec_mark != held_q))) begin
					first_q <= 1'b1;
					start_q <= cnt_q;
					held_q  <= dec_mark;
				end
			end
		end
	end

	// flush returns the tracker to its reset state
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		beat && is_flush |=> (cnt_q == '0) && !first_q && (fill_q == '0))
		else $error("flush did not clear run state");

	// a change emit only happens once the first element is known
	a_emit_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid && !is_flush |-> first_q && (dec_mark != held_q))
		else $error("element emitted without a decided change");

	// history fill saturates at the depth
	a_fill_sat: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !is_flush && (fill_q == FILL_W'(HISTORY_DEPTH))
		|=> fill_q == FILL_W'(HISTORY_DEPTH))
		else $error("history fill left saturation");

endmodule

>>> rtl/mark_space_run_detector_top.sv
`timescale 1ns / 1ps
// result path: the input beat that ends an element loads it into the s1 register, and the result beat is
// offered from the result register behind it; throughput: one input beat per cycle, sustained while the
// result stream is not back-pressured; the run tracker and the duration multiplier stage are parted by the s1 register
// reset: arst_n clears the run state and pipeline valids at once, the agree count
// returns to 4 and the sample period to 5805
module mark_space_run_detector_top #(
	parameter int HISTORY_DEPTH = msrd_pkg::DEF_HISTORY_DEPTH,
	parameter int COUNT_WIDTH   = msrd_pkg::DEF_COUNT_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [msrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msrd_pkg::CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,  // [15:0] sample
	input  logic                           s_tuser,  // [0] command
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [87:0]                    m_tdata,  // [31:0] element_samples, [87:32] element_duration
	output logic                           m_tuser,  // [0] element_is_mark
	output logic                           m_tlast   // final_element
);
	import msrd_pkg::*;

	localparam int PROD_W = COUNT_WIDTH + SPACING_W;

	logic [CC_W-1:0]      agree_n_q;
	logic [SPACING_W-1:0] spacing_q;

	logic                   beat;
	emit_t                  ev;
	logic [COUNT_WIDTH-1:0] ev_len;

	logic                   valid_s1;
	logic                   mark_s1;
	logic                   last_s1;
	logic [COUNT_WIDTH-1:0] len_s1;

	logic                   out_valid_q;
	logic                   out_mark_q;
	logic                   out_last_q;
	logic [SAMPLES_W-1:0]   samples_q;
	logic [DURATION_W-1:0]  duration_q;

	logic                   out_load;
	logic                   adv_s1;
	logic [PROD_W-1:0]      prod;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agree_n_q <= CC_RESET;
			spacing_q <= SPACING_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AGREE_N: agree_n_q <= cfg_data[CC_W-1:0];
				REG_SPACING: spacing_q <= cfg_data[SPACING_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign out_load = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && out_load;
	assign s_tready = !valid_s1 || out_load;
	assign beat     = s_tvalid && s_tready;

	msrd_tracker #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.beat   (beat),
		.command(s_tuser),
		.sample (s_tdata),
		.agree_n(agree_n_q),
		.ev     (ev),
		.ev_len (ev_len)
	);

	// element register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ev.valid) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.valid) begin
			mark_s1 <= ev.mark;
			last_s1 <= ev.flush;
			len_s1  <= ev_len;
		end
	end

	// duration = length times spacing
	assign prod = PROD_W'(len_s1) * PROD_W'(spacing_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_mark_q <= mark_s1;
			out_last_q <= last_s1;
			samples_q  <= SAMPLES_W'(len_s1);
			duration_q <= DURATION_W'(prod);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {duration_q, samples_q};
	assign m_tuser  = out_mark_q;
	assign m_tlast  = out_last_q;

endmodule
